FILE: rtl/core/hsvbd_pkg.sv
package hsvbd_pkg;

  localparam int NUM_W   = 17;  // min(sat) * |dh| + 180 * |ds|
  localparam int SUM_W   = 18;  // dh^2 + ds^2 + dv^2
  localparam int ROOT_W  = 17;  // distance, 8 fraction bits
  localparam int REM_W   = 20;  // square root partial remainder
  localparam int SCALE_W = 17;  // scaler, Q1.16
  localparam int PROD_W  = ROOT_W + SCALE_W;

  localparam logic [NUM_W-1:0]   SAT_DIVISOR = NUM_W'(45900);  // 180 * 255
  localparam logic [NUM_W-1:0]   HUE_WEIGHT  = NUM_W'(180);
  localparam logic [SCALE_W-1:0] SCALER_ONE  = SCALE_W'(65536);
  localparam int                 PROD_SHIFT  = 24;
  localparam logic [7:0]         DIFF_MAX    = 8'd255;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_state_t;

  // one radix-4 digit of the restoring square root
  function automatic sqrt_state_t sqrt_step(input sqrt_state_t st, input logic [1:0] pair);
    sqrt_state_t      res;
    logic [REM_W-1:0] acc;
    logic [REM_W-1:0] trial;
    acc   = {st.rem[REM_W-3:0], pair};
    trial = {1'b0, st.root, 2'b01};
    if (acc >= trial) begin
      res.rem  = acc - trial;
      res.root = {st.root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = acc;
      res.root = {st.root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

  // largest y in Q1.16 with (y / 2^16)^10 <= (idx / 2^bits)^3, evaluated at elaboration
  function automatic logic [SCALE_W-1:0] pow_entry(input int unsigned idx,
                                                   input int unsigned bits);
    logic [223:0]         lhs;
    logic [223:0]         rhs;
    logic [SCALE_W-1:0]   y;
    logic [SCALE_W-1:0]   cand;
    int                   b;
    int                   k;
    y   = '0;
    rhs = 224'd1;
    for (k = 0; k < 3; k++) rhs = rhs * 224'(idx);
    rhs = rhs << 160;
    for (b = SCALE_W - 1; b >= 0; b--) begin
      cand = y | (SCALE_W'(1) << b);
      if (cand <= SCALER_ONE) begin
        lhs = 224'd1;
        for (k = 0; k < 10; k++) lhs = lhs * 224'(cand);
        lhs = lhs << (3 * bits);
        if (lhs <= rhs) y = cand;
      end
    end
    return y;
  endfunction

endpackage

FILE: rtl/core/hsvbd_in_if.sv
interface hsvbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_hue;
  logic [7:0] pixel_sat;
  logic [7:0] pixel_val;
  logic [7:0] bg_hue;
  logic [7:0] bg_sat;
  logic [7:0] bg_val;

  modport source (
    output valid, pixel_hue, pixel_sat, pixel_val, bg_hue, bg_sat, bg_val,
    input  ready
  );
  modport sink (
    input  valid, pixel_hue, pixel_sat, pixel_val, bg_hue, bg_sat, bg_val,
    output ready
  );
endinterface

FILE: rtl/core/hsvbd_out_if.sv
interface hsvbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] difference;

  modport source (
    output valid, difference,
    input  ready
  );
  modport sink (
    input  valid, difference,
    output ready
  );
endinterface

FILE: rtl/core/hsvbd_isqrt.sv
module hsvbd_isqrt (
  input  logic                        clk,
  input  logic [3:0]                  en,
  input  logic [hsvbd_pkg::SUM_W-1:0] sum_i,
  output logic [hsvbd_pkg::ROOT_W-1:0] root_o
);
  import hsvbd_pkg::*;

  localparam int NSTAGE = 4;

  // radicand is sum * 2^16, 17 digit pairs: 5 in the first stage, 4 in each after
  logic [SUM_W-1:0] x_r   [NSTAGE];
  sqrt_state_t      st_r  [NSTAGE];
  logic [SUM_W-1:0] x_nxt [NSTAGE];
  sqrt_state_t      st_nxt[NSTAGE];

  always_comb begin
    sqrt_state_t        st;
    logic [2*SUM_W-3:0] xw;
    int                 hi;
    int                 cnt;
    for (int s = 0; s < NSTAGE; s++) begin
      if (s == 0) begin
        x_nxt[s] = sum_i;
        st       = '0;
        hi       = 16;
        cnt      = 5;
      end else begin
        x_nxt[s] = x_r[s-1];
        st       = st_r[s-1];
        hi       = 15 - 4 * s;
        cnt      = 4;
      end
      xw = {x_nxt[s], 16'b0};
      for (int j = 0; j < 5; j++) begin
        if (j < cnt) st = sqrt_step(st, xw[2 * (hi - j) +: 2]);
      end
      st_nxt[s] = st;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NSTAGE; s++) begin
      if (en[s]) begin
        x_r[s]  <= x_nxt[s];
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign root_o = st_r[NSTAGE-1].root;

endmodule

FILE: rtl/core/hsv_background_difference.sv
// HSV background difference, one pixel per item.
// in_ch carries a frame pixel and the matching background pixel (hue, saturation,
// value, 8 bits each); out_ch returns one 8-bit difference per item, in order.
// Both channels move an item on a clock edge with valid and ready high.
// An accepted item moves through the stage registers 1 to 7, in order, to out_ch.
// Throughput is one item per clock while out_ch is ready: the seven-stage
// pipeline takes a new item every cycle; the integer square root is spread over four of those stages and
// the power table is read through a registered lookup in stage five.
// The power table has 2^POWER_TABLE_BITS entries and is fixed at elaboration.
// Reset (rst_n low, synchronous) clears all stage valid bits; no result is shown
// until an item has been accepted and has run through.
// When out_ch.ready is low the result holds in the output register and each stage
// with only full stages after it holds its item; other items move on into empty
// stages, so in_ch.ready only drops once every stage holds an item.
module hsv_background_difference #(
  parameter int POWER_TABLE_BITS = 10
) (
  input  logic         clk,
  input  logic         rst_n,
  hsvbd_in_if.sink     in_ch,
  hsvbd_out_if.source  out_ch
);
  import hsvbd_pkg::*;

  localparam int TB        = POWER_TABLE_BITS;
  localparam int POW_DEPTH = 1 << TB;
  localparam int QW        = TB + 2;
  localparam int RW        = TB + NUM_W + 1;
  localparam int QSHIFT    = 32 - TB;
  localparam int RP_W      = 2 * NUM_W;
  localparam logic [NUM_W-1:0] RECIP = NUM_W'((64'd1 << 32) / 64'(SAT_DIVISOR));

  // stage handshake
  logic [7:1] valid_r;
  logic [7:1] valid_in;
  logic [7:1] en;

  always_comb begin
    en[7] = !valid_r[7] || out_ch.ready;
    for (int k = 6; k >= 1; k--) en[k] = !valid_r[k] || en[k+1];
  end

  assign valid_in    = {valid_r[6:1], in_ch.valid};
  assign in_ch.ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 1; k <= 7; k++) begin
        if (en[k]) valid_r[k] <= valid_in[k];
      end
    end
  end

  // stage 1: channel differences
  logic [7:0] dh1_r, ds1_r, dv1_r, smin1_r;
  logic [7:0] dh1_nxt, ds1_nxt, dv1_nxt, smin1_nxt;

  always_comb begin
    dh1_nxt   = (in_ch.pixel_hue > in_ch.bg_hue) ? in_ch.pixel_hue - in_ch.bg_hue
                                                 : in_ch.bg_hue - in_ch.pixel_hue;
    ds1_nxt   = (in_ch.pixel_sat > in_ch.bg_sat) ? in_ch.pixel_sat - in_ch.bg_sat
                                                 : in_ch.bg_sat - in_ch.pixel_sat;
    dv1_nxt   = (in_ch.pixel_val > in_ch.bg_val) ? in_ch.pixel_val - in_ch.bg_val
                                                 : in_ch.bg_val - in_ch.pixel_val;
    smin1_nxt = (in_ch.pixel_sat < in_ch.bg_sat) ? in_ch.pixel_sat : in_ch.bg_sat;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dh1_r   <= dh1_nxt;
      ds1_r   <= ds1_nxt;
      dv1_r   <= dv1_nxt;
      smin1_r <= smin1_nxt;
    end
  end

  // stage 2: weight numerator and squared distance
  logic [NUM_W-1:0] num2_r, num2_nxt;
  logic [SUM_W-1:0] sum2_r, sum2_nxt;

  always_comb begin
    num2_nxt = NUM_W'(smin1_r) * NUM_W'(dh1_r) + HUE_WEIGHT * NUM_W'(ds1_r);
    sum2_nxt = SUM_W'(dh1_r) * SUM_W'(dh1_r) + SUM_W'(ds1_r) * SUM_W'(ds1_r)
             + SUM_W'(dv1_r) * SUM_W'(dv1_r);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      num2_r <= num2_nxt;
      sum2_r <= sum2_nxt;
    end
  end

  // stage 3: reciprocal multiply for num * 2^TB / 45900
  logic [RP_W-1:0]  rp3_r, rp3_nxt;
  logic [NUM_W-1:0] num3_r;
  logic             sat3_r, sat3_nxt;

  assign rp3_nxt  = RP_W'(num2_r) * RP_W'(RECIP);
  assign sat3_nxt = num2_r >= SAT_DIVISOR;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      rp3_r  <= rp3_nxt;
      num3_r <= num2_r;
      sat3_r <= sat3_nxt;
    end
  end

  // stage 4: quotient estimate is low by at most one, fix with the remainder
  logic [QW-1:0] q_c;
  logic [RW-1:0] lhs_c, qm_c, r_c;
  logic [TB-1:0] idx4_r, idx4_nxt;
  logic          sat4_r;

  always_comb begin
    q_c      = rp3_r[QSHIFT +: QW];
    lhs_c    = {1'b0, num3_r, {TB{1'b0}}};
    qm_c     = RW'(q_c) * RW'(SAT_DIVISOR);
    r_c      = lhs_c - qm_c;
    idx4_nxt = q_c[TB-1:0] + TB'(r_c >= RW'(SAT_DIVISOR));
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      idx4_r <= idx4_nxt;
      sat4_r <= sat3_r;
    end
  end

  // stage 5: power table lookup
  logic [SCALE_W-1:0] pow_rom [POW_DEPTH];

  for (genvar g = 0; g < POW_DEPTH; g++) begin : g_pow
    localparam logic [SCALE_W-1:0] ENTRY = pow_entry(g, TB);
    assign pow_rom[g] = ENTRY;
  end

  logic [SCALE_W-1:0] scaler5_r, scaler5_nxt;
  logic [SCALE_W-1:0] scaler6_r;

  assign scaler5_nxt = sat4_r ? SCALER_ONE : pow_rom[idx4_r];

  always_ff @(posedge clk) begin
    if (en[5]) scaler5_r <= scaler5_nxt;
    if (en[6]) scaler6_r <= scaler5_r;
  end

  // stages 3 to 6: distance square root
  logic [ROOT_W-1:0] root6;

  hsvbd_isqrt u_isqrt (
    .clk    (clk),
    .en     (en[6:3]),
    .sum_i  (sum2_r),
    .root_o (root6)
  );

  // stage 7: weight the distance and saturate
  logic [PROD_W-1:0]            prod_c;
  logic [PROD_W-PROD_SHIFT-1:0] high_c;
  logic [7:0]                   diff7_r, diff7_nxt;

  always_comb begin
    prod_c    = PROD_W'(root6) * PROD_W'(scaler6_r);
    high_c    = prod_c[PROD_W-1:PROD_SHIFT];
    diff7_nxt = (|high_c[PROD_W-PROD_SHIFT-1:8]) ? DIFF_MAX : high_c[7:0];
  end

  always_ff @(posedge clk) begin
    if (en[7]) diff7_r <= diff7_nxt;
  end

  assign out_ch.valid      = valid_r[7];
  assign out_ch.difference = diff7_r;

  // an empty output stage never blocks the input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r[7] |-> in_ch.ready)
    else $error("input stalled with empty output stage");

  // reciprocal estimate must be within one of the true quotient
  a_quotient_close: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[3] && !sat3_r |-> r_c < (RW'(SAT_DIVISOR) << 1))
    else $error("quotient estimate off by more than one");

  a_sat_scaler: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[4] && sat4_r && en[5] |=> scaler5_r == SCALER_ONE)
    else $error("saturated weight did not give unit scaler");

  a_zero_scaler: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[6] && en[7] && scaler6_r == '0 |=> out_ch.difference == '0)
    else $error("zero scaler gave nonzero difference");

endmodule

FILE: test/hsv_background_difference_checker.sv
`timescale 1ns / 100ps

module hsv_background_difference_checker #(
  parameter int TABLE_BITS = 10
) (
  input  logic   clk,
  input  logic   rst_n,
  hsvbd_in_if    in_mon,
  hsvbd_out_if   out_mon,
  output int     mismatches,
  output int     pending,
  output int     compared
);

  localparam longint unsigned SAT_HUE_RANGE = 45900;  // 255 * 180
  localparam longint unsigned T_ONE         = 65536;  // 1.0 in Q1.16

  logic [16:0] pow03_lut [0:(1 << TABLE_BITS) - 1];
  logic [7:0]  diff_q [$];
  int          error_count;
  int          result_count;

  // largest y with (y / 2^16)^10 <= (idx / 2^TABLE_BITS)^3, found by bisection
  function automatic logic [16:0] pow03_floor(input int unsigned idx);
    logic [255:0]    lhs;
    logic [255:0]    rhs;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     mid;
    lo  = 0;
    hi  = 65536;
    rhs = 256'(idx) * 256'(idx) * 256'(idx);
    rhs = rhs << 160;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = 256'd1;
      for (int k = 0; k < 10; k++) lhs = lhs * 256'(mid);
      lhs = lhs << (3 * TABLE_BITS);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return 17'(lo);
  endfunction

  function automatic longint unsigned dist_q8(input longint unsigned sq);
    longint unsigned root;
    longint unsigned cand;
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= sq) root = cand;
    end
    return root;
  endfunction

  function automatic logic [7:0] weighted_difference(
    input logic [7:0] ph, input logic [7:0] ps, input logic [7:0] pv,
    input logic [7:0] bh, input logic [7:0] bs, input logic [7:0] bv
  );
    longint unsigned dh;
    longint unsigned ds;
    longint unsigned dv;
    longint unsigned sat_min;
    longint unsigned weight;
    longint unsigned t_q16;
    longint unsigned scaler;
    longint unsigned root_dist;
    longint unsigned prod;
    dh      = (ph > bh) ? longint'(ph - bh) : longint'(bh - ph);
    ds      = (ps > bs) ? longint'(ps - bs) : longint'(bs - ps);
    dv      = (pv > bv) ? longint'(pv - bv) : longint'(bv - pv);
    sat_min = (ps < bs) ? longint'(ps) : longint'(bs);
    weight  = sat_min * dh + 180 * ds;
    t_q16   = (weight << 16) / SAT_HUE_RANGE;
    if (t_q16 >= T_ONE) scaler = T_ONE;
    else scaler = longint'(pow03_lut[t_q16 >> (16 - TABLE_BITS)]);
    root_dist = dist_q8((dh * dh + ds * ds + dv * dv) << 16);
    prod = (root_dist * scaler) >> 24;
    if (prod > 255) prod = 255;
    return prod[7:0];
  endfunction

  initial begin
    error_count  = 0;
    result_count = 0;
    for (int i = 0; i < (1 << TABLE_BITS); i++) pow03_lut[i] = pow03_floor(i);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        result_count++;
        if (diff_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected difference item: expected none, actual %0d",
                   $time, out_mon.difference);
        end else begin
          if (out_mon.difference !== diff_q[0]) begin
            error_count++;
            $display("%0t: difference mismatch: expected %0d, actual %0d",
                     $time, diff_q[0], out_mon.difference);
          end
          void'(diff_q.pop_front());
        end
      end
      if (in_mon.valid && in_mon.ready)
        diff_q = {diff_q, weighted_difference(in_mon.pixel_hue, in_mon.pixel_sat,
                                              in_mon.pixel_val, in_mon.bg_hue,
                                              in_mon.bg_sat, in_mon.bg_val)};
    end
    mismatches <= error_count;
    pending    <= diff_q.size();
    compared   <= result_count;
  end

endmodule

FILE: test/hsv_background_difference_tb.sv
`timescale 1ns / 100ps

module hsv_background_difference_tb;

  localparam int TABLE_BITS   = 10;
  localparam int RANDOM_ITEMS = 1930;
  localparam int HUE_TOP      = 179;

  logic clk = 1'b0;
  logic rst_n;
  logic no_stall;
  int   pixels_sent;
  int   directed_count;
  int   mismatches;
  int   pending;
  int   compared;

  hsvbd_in_if  in_ch ();
  hsvbd_out_if out_ch ();

  hsv_background_difference #(
    .POWER_TABLE_BITS(TABLE_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hsv_background_difference_checker #(
    .TABLE_BITS(TABLE_BITS)
  ) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .compared   (compared)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= no_stall || ($urandom_range(0, 99) >= 10);
    end
  end

  initial begin
    #4ms;
    $display("hsv_background_difference_tb: done, errors");
    $finish;
  end

  task automatic send_pixel(input logic [7:0] ph, input logic [7:0] ps, input logic [7:0] pv,
                            input logic [7:0] bh, input logic [7:0] bs,
                            input logic [7:0] bv);
    while (!no_stall && $urandom_range(0, 99) < 10) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.pixel_hue <= ph;
    in_ch.pixel_sat <= ps;
    in_ch.pixel_val <= pv;
    in_ch.bg_hue    <= bh;
    in_ch.bg_sat    <= bs;
    in_ch.bg_val    <= bv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pixels_sent++;
  endtask

  // background close to the frame pixel, where the scaler table is used at small t
  function automatic logic [7:0] nudge(input logic [7:0] x, input int top);
    int v;
    v = int'(x) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return 8'(v);
  endfunction

  function automatic logic [7:0] pick_edge(input int top);
    case ($urandom_range(0, 2))
      0: return 8'd0;
      1: return 8'(top);
      default: return 8'($urandom_range(0, top));
    endcase
  endfunction

  initial begin
    int         mode;
    int         hue_top;
    logic [7:0] ph;
    logic [7:0] ps;
    logic [7:0] pv;
    logic [7:0] bh;
    logic [7:0] bs;
    logic [7:0] bv;

    pixels_sent     = 0;
    no_stall        = 1'b0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.pixel_hue <= 8'd0;
    in_ch.pixel_sat <= 8'd0;
    in_ch.pixel_val <= 8'd0;
    in_ch.bg_hue    <= 8'd0;
    in_ch.bg_sat    <= 8'd0;
    in_ch.bg_val    <= 8'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pixel(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
    send_pixel(8'd179, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd0,   8'd179, 8'd255, 8'd255);
    // hue out of range with full saturation, t clamps at one
    send_pixel(8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd0);
    // same hue and saturation: zero scaler whatever the value step
    send_pixel(8'd100, 8'd128, 8'd0,   8'd100, 8'd128, 8'd255);
    // zero saturation hides the hue step
    send_pixel(8'd0,   8'd0,   8'd255, 8'd179, 8'd0,   8'd0);
    send_pixel(8'd90,  8'd200, 8'd40,  8'd90,  8'd201, 8'd40);
    send_pixel(8'd255, 8'd0,   8'd0,   8'd255, 8'd255, 8'd255);
    // largest distance, product saturates
    send_pixel(8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0);
    send_pixel(8'd10,  8'd50,  8'd128, 8'd12,  8'd50,  8'd128);
    send_pixel(8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd128, 8'd0,   8'd0,   8'd0,   8'd0);
    send_pixel(8'd170, 8'd10,  8'd200, 8'd20,  8'd250, 8'd30);
    send_pixel(8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0);
    send_pixel(8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd127, 8'd64,  8'd64,  8'd128, 8'd127);
    send_pixel(8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255, 8'd255, 8'd0,   8'd0);
    send_pixel(8'd179, 8'd1,   8'd255, 8'd0,   8'd1,   8'd254);
    directed_count = pixels_sent;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_stall = (n >= 800 && n < 1200);
      mode     = $urandom_range(0, 99);
      hue_top  = (mode < 85) ? HUE_TOP : 255;
      ph = 8'($urandom_range(0, hue_top));
      ps = 8'($urandom_range(0, 255));
      pv = 8'($urandom_range(0, 255));
      bh = 8'($urandom_range(0, hue_top));
      bs = 8'($urandom_range(0, 255));
      bv = 8'($urandom_range(0, 255));
      if (mode < 30) begin
        bh = nudge(ph, hue_top);
        bs = nudge(ps, 255);
        bv = nudge(pv, 255);
      end else if (mode < 40) begin
        bs = ps;
      end else if (mode < 55) begin
        ph = pick_edge(hue_top);
        ps = pick_edge(255);
        pv = pick_edge(255);
        bh = pick_edge(hue_top);
        bs = pick_edge(255);
        bv = pick_edge(255);
      end
      send_pixel(ph, ps, pv, bh, bs, bv);
    end
    in_ch.valid <= 1'b0;
    no_stall    = 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("%0d pixel pairs sent (%0d directed, rest random with stalls on both sides),",
             pixels_sent, directed_count);
    $display("%0d difference items compared", compared);
    if (mismatches == 0 && pending == 0) begin
      $display("hsv_background_difference_tb: done, clean");
    end else begin
      $display("hsv_background_difference_tb: done, errors");
    end
    $finish;
  end

endmodule
